// File: design/ogi_pkg.sv
// ogi_pkg: shared types and constants for the occupancy grid inflation block
// holds command codes, register indexes, fsm states, control structs and the disk table
// no dependencies
package ogi_pkg;

  localparam int CmdW   = 2;
  localparam int CoordW = 8;
  localparam int OccW   = 8;
  localparam int CfgW   = 9;
  localparam int RadW   = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 8;
  localparam int ObstacleThreshold = 50;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_DATA,
    ST_WR_READ,
    ST_WR_WRITE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic rd_issue;
    logic out_load;
    logic paint_init;
    logic paint_read;
    logic paint_write;
  } ogi_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic in_map;
    logic clr_last;
    logic paint_last;
    logic out_free;
  } ogi_stat_t;

  // half chord of the disk, indexed by {radius, row distance}
  typedef logic [255:0][RadW-1:0] hw_tab_t;

  function automatic hw_tab_t build_hw_tab();
    hw_tab_t tab;
    tab = '0;
    for (int r = 0; r < 16; r++) begin
      for (int d = 0; d < 16; d++) begin
        for (int h = 0; h < 16; h++) begin
          if (h * h + d * d <= r * r) begin
            tab[r * 16 + d] = RadW'(h);
          end
        end
      end
    end
    return tab;
  endfunction

  localparam hw_tab_t HW_TAB = build_hw_tab();

endpackage

// File: design/ogi_ctrl.sv
// ogi_ctrl: sequencer for clear sweeps, cell reads and disk painting
// drives ogi_dp through ogi_cmd_t and watches ogi_stat_t; uses ogi_pkg
module ogi_ctrl
  import ogi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  ogi_stat_t stat_i,
  output ogi_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clr_init = 1'b1;
            state_d        = ST_CLEAR;
          end
          CMD_WRITE: begin
            if (stat_i.in_map) begin
              cmd_o.paint_init = 1'b1;
              state_d          = ST_WR_READ;
            end else begin
              state_d = ST_IDLE;
            end
          end
          CMD_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_RD_DATA;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_RD_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_WR_READ: begin
        cmd_o.paint_read = 1'b1;
        state_d          = ST_WR_WRITE;
      end
      ST_WR_WRITE: begin
        cmd_o.paint_write = 1'b1;
        state_d = stat_i.paint_last ? ST_IDLE : ST_WR_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/ogi_dp.sv
// ogi_dp: configuration registers, row-wide bitmap memories, disk row masks and result register
// obeys ogi_cmd_t from ogi_ctrl and reports ogi_stat_t; uses ogi_pkg
module ogi_dp
  import ogi_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [CmdW-1:0]     s_axis_tuser,
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  ogi_cmd_t            cmd_i,
  output ogi_stat_t           stat_o
);

  localparam int WB = ($clog2(MAX_WIDTH + 1) > CfgW) ? $clog2(MAX_WIDTH + 1) : CfgW;
  localparam int HB = ($clog2(MAX_HEIGHT + 1) > CfgW) ? $clog2(MAX_HEIGHT + 1) : CfgW;
  localparam int XS = WB + 1;
  localparam int RS = HB + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(MAX_HEIGHT);

  logic [CfgW-1:0] map_width_q, map_height_q;
  logic [RadW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= CfgW'(256);
      map_height_q <= CfgW'(256);
      radius_q     <= RadW'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        CFG_RADIUS:     radius_q     <= cfg_data_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0]   eff_w;
  logic [HB-1:0]   eff_h;
  logic [RadW-1:0] eff_r;

  always_comb begin
    eff_w = (WB'(map_width_q) > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(map_width_q);
    eff_h = (HB'(map_height_q) > HB'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(map_height_q);
    eff_r = (int'(radius_q) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : radius_q;
  end

  // item registers
  cmd_e              cmd_q;
  logic [CoordW-1:0] x_q, y_q;
  logic              obst_q;
  logic signed [OccW-1:0] occ;

  assign occ = $signed(s_axis_tdata[23:16]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      x_q    <= s_axis_tdata[7:0];
      y_q    <= s_axis_tdata[15:8];
      obst_q <= (occ > OccW'(ObstacleThreshold)) || (occ < 0);
    end
  end

  logic in_map;
  logic [CW-1:0] x_col;
  assign in_map = (WB'(x_q) < eff_w) && (HB'(y_q) < eff_h);
  assign x_col  = CW'(x_q);

  // clear sweep
  logic [AW-1:0] clr_q;
  logic          clr_last;
  assign clr_last = (clr_q == AW'(MAX_HEIGHT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // disk row walk
  logic signed [RS-1:0] cur_row_q, end_row_q;
  logic signed [RS-1:0] y_s, r_s, row_diff;
  logic [RS-1:0]        row_abs;
  logic [RadW-1:0]      row_dist, hw;
  logic                 row_ok;
  logic signed [XS-1:0] col_lo, col_hi;
  logic [MAX_WIDTH-1:0] mask;

  assign y_s = signed'(RS'(y_q));
  assign r_s = signed'(RS'(eff_r));

  always_comb begin
    row_diff = cur_row_q - y_s;
    row_abs  = (row_diff < 0) ? RS'(-row_diff) : RS'(row_diff);
    row_dist = row_abs[RadW-1:0];
    hw       = HW_TAB[{eff_r, row_dist}];
    row_ok   = (cur_row_q >= 0) && (cur_row_q < signed'(RS'(eff_h)));
    col_lo   = signed'(XS'(x_q)) - signed'(XS'(hw));
    col_hi   = signed'(XS'(x_q)) + signed'(XS'(hw));
    for (int j = 0; j < MAX_WIDTH; j++) begin
      mask[j] = obst_q && (XS'(j) >= col_lo) && (XS'(j) <= col_hi) && (WB'(j) < eff_w);
    end
  end

  logic                 row_ok_q, center_q;
  logic [AW-1:0]        row_addr_q;
  logic [MAX_WIDTH-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      end_row_q <= '0;
      row_ok_q  <= 1'b0;
    end else if (cmd_i.paint_init) begin
      cur_row_q <= obst_q ? (y_s - r_s) : y_s;
      end_row_q <= obst_q ? (y_s + r_s) : y_s;
    end else if (cmd_i.paint_read) begin
      row_ok_q <= row_ok;
    end else if (cmd_i.paint_write) begin
      cur_row_q <= cur_row_q + RS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.paint_read) begin
      mask_q     <= mask;
      center_q   <= (cur_row_q == y_s);
      row_addr_q <= cur_row_q[AW-1:0];
    end
  end

  // bitmap memories, one row per word
  logic [MAX_WIDTH-1:0] inf_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] raw_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_inf_q, rd_raw_q;
  logic [MAX_WIDTH-1:0] wr_inf, wr_raw;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 rd_en, wr_en;

  always_comb begin
    rd_en   = cmd_i.rd_issue || cmd_i.paint_read;
    rd_addr = cmd_i.rd_issue ? AW'(y_q) : cur_row_q[AW-1:0];
    wr_en   = cmd_i.clr_step || (cmd_i.paint_write && row_ok_q);
    wr_addr = cmd_i.clr_step ? clr_q : row_addr_q;
    wr_inf  = rd_inf_q | mask_q;
    wr_raw  = rd_raw_q;
    if (center_q) begin
      wr_raw[x_col] = obst_q;
    end
    if (cmd_i.clr_step) begin
      wr_inf = '0;
      wr_raw = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      inf_mem[wr_addr] <= wr_inf;
      raw_mem[wr_addr] <= wr_raw;
    end
    if (rd_en) begin
      rd_inf_q <= inf_mem[rd_addr];
      rd_raw_q <= raw_mem[rd_addr];
    end
  end

  // result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {5'b0, !in_map, in_map && rd_raw_q[x_col], in_map && rd_inf_q[x_col]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.in_map     = in_map;
    stat_o.clr_last   = clr_last;
    stat_o.paint_last = (cur_row_q == end_row_q);
    stat_o.out_free   = out_free;
  end

endmodule

// File: design/occupancy_grid_inflation_top.sv
// occupancy_grid_inflation_top: occupancy grid with raw and disk-inflated obstacle bitmaps
// joins ogi_ctrl and ogi_dp; uses ogi_pkg
//
// input stream: tuser carries the command (clear, write cell, read cell), tdata the cell
// coordinates and occupancy. a write of an obstacle (above 50 or negative) marks the raw
// bit and ORs a disk of the configured radius into the inflated map; a free value clears
// the raw bit only. a read returns one item on the output stream: blocked, raw obstacle
// and out-of-map flags. clear zeroes both maps.
// both maps are stored one grid row per memory word; painting does a read-modify-write per
// row, over the centre row for a free cell and over the 2R+1 rows of the disk for an
// obstacle, writing back only rows inside the map; a write outside the map or an unused
// command paints nothing. a read passes through dispatch, a memory read and the load of
// the result register; clear sweeps all MAX_HEIGHT rows of both memories, as does a pass
// after reset, both with s_axis_tready low; a new item is taken only once the last is done.
// the result sits in an output register; while the receiver stalls, non-read items are
// still accepted and a following read waits until that register is free.
// configuration writes take effect on the next clock edge and should be made while idle.
module occupancy_grid_inflation_top
  import ogi_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CmdW-1:0]     s_axis_tuser,  // cmd
  input  logic [InDataW-1:0]  s_axis_tdata,  // cell_x, cell_y, occupancy
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // blocked, raw_obstacle, out_of_map, zero fill
);

  ogi_cmd_t  cmd;
  ogi_stat_t stat;

  ogi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  ogi_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

// File: tb/tb_occupancy_grid_inflation_top.sv
`timescale 1ns / 1ps
// tb_occupancy_grid_inflation_top: self-checking bench for the occupancy grid inflation block
// keeps its own raw and inflated grid to predict every read; uses ogi_pkg and the top level
module tb_occupancy_grid_inflation_top;
  import ogi_pkg::*;

  localparam int GridCols = 256;
  localparam int GridRows = 256;
  localparam int RadiusCap = 15;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int SettleCycles = 300;
  localparam int CycleLimit = 1_000_000;
  localparam int SegItems = 125;
  localparam int SegCount = 8;

  typedef struct packed {
    logic blocked;
    logic raw_obstacle;
    logic out_of_map;
  } cell_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CmdW-1:0]     s_axis_tuser = '0;   // cmd
  logic [InDataW-1:0]  s_axis_tdata = '0;   // cell_x, cell_y, occupancy
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // blocked, raw_obstacle, out_of_map, zero fill

  occupancy_grid_inflation_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // grid copy and register copy
  bit              raw_bits[int];
  bit              infl_bits[int];
  logic [CfgW-1:0] width_cfg = 9'd256;
  logic [CfgW-1:0] height_cfg = 9'd256;
  logic [RadW-1:0] radius_cfg = 4'd3;
  cell_status_t    read_back_q[$];

  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit rx_hold = 1'b0;
  int hold_req = 0;
  int rx_stall = 0;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int reg_writes = 0;
  int clears_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int grid_cols();
    return (width_cfg > GridCols) ? GridCols : int'(width_cfg);
  endfunction

  function automatic int grid_rows();
    return (height_cfg > GridRows) ? GridRows : int'(height_cfg);
  endfunction

  function automatic void grid_step(logic [CmdW-1:0] cmd, logic [7:0] x, logic [7:0] y,
                                    int occ);
    int w, h, r, nx, ny, idx;
    bit in_map, obst;
    cell_status_t st;
    w = grid_cols();
    h = grid_rows();
    r = (int'(radius_cfg) > RadiusCap) ? RadiusCap : int'(radius_cfg);
    in_map = (int'(x) < w) && (int'(y) < h);
    idx = int'(y) * GridCols + int'(x);
    case (cmd)
      CMD_CLEAR: begin
        raw_bits.delete();
        infl_bits.delete();
      end
      CMD_WRITE: begin
        if (in_map) begin
          obst = (occ > ObstacleThreshold) || (occ < 0);
          raw_bits[idx] = obst;
          if (obst) begin
            for (int dy = -r; dy <= r; dy++) begin
              for (int dx = -r; dx <= r; dx++) begin
                nx = int'(x) + dx;
                ny = int'(y) + dy;
                if (dx * dx + dy * dy <= r * r && nx >= 0 && nx < w && ny >= 0 && ny < h) begin
                  infl_bits[ny * GridCols + nx] = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (!in_map) begin
          st = '{blocked: 1'b0, raw_obstacle: 1'b0, out_of_map: 1'b1};
        end else begin
          st.blocked = infl_bits.exists(idx) ? infl_bits[idx] : 1'b0;
          st.raw_obstacle = raw_bits.exists(idx) ? raw_bits[idx] : 1'b0;
          st.out_of_map = 1'b0;
        end
        read_back_q.insert(read_back_q.size(), st);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, cell_status_t want, cell_status_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: blocked exp %0b got %0b, raw_obstacle exp %0b got %0b, out_of_map exp %0b got %0b",
               $time, what, want.blocked, got.blocked, want.raw_obstacle, got.raw_obstacle,
               want.out_of_map, got.out_of_map);
    end
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] occ);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {occ, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    grid_step(cmd, x, y, int'($signed(occ)));
    items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (read_back_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:  width_cfg = val;
      CFG_MAP_HEIGHT: height_cfg = val;
      CFG_RADIUS:     radius_cfg = val[RadW-1:0];
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  task automatic configure(input int w, input int h, input int r);
    wait_idle();
    set_reg(CFG_MAP_WIDTH, CfgW'(w));
    set_reg(CFG_MAP_HEIGHT, CfgW'(h));
    set_reg(CFG_RADIUS, CfgW'(r));
  endtask

  // disk edges, threshold edges, free rewrite, unused command and clear
  task automatic test_directed();
    configure(256, 256, 3);
    send_item(CMD_READ, 8'd0, 8'd0, 8'd0);
    send_item(CMD_WRITE, 8'd10, 8'd10, 8'd51);
    send_item(CMD_READ, 8'd10, 8'd10, 8'd0);
    send_item(CMD_READ, 8'd13, 8'd10, 8'd0);
    send_item(CMD_READ, 8'd12, 8'd12, 8'd0);
    send_item(CMD_READ, 8'd13, 8'd11, 8'd0);
    send_item(CMD_WRITE, 8'd100, 8'd100, 8'd50);
    send_item(CMD_READ, 8'd100, 8'd100, 8'd0);
    send_item(CMD_WRITE, 8'd255, 8'd255, 8'hFF);
    send_item(CMD_READ, 8'd252, 8'd255, 8'd0);
    send_item(CMD_WRITE, 8'd0, 8'd255, 8'd127);
    send_item(CMD_WRITE, 8'd128, 8'd0, 8'h80);
    send_item(CMD_READ, 8'd128, 8'd3, 8'd0);
    send_item(CMD_WRITE, 8'd10, 8'd10, 8'd0);
    send_item(CMD_READ, 8'd10, 8'd10, 8'd0);
    send_item(CMD_UNUSED, 8'd7, 8'd7, 8'd100);
    send_item(CMD_READ, 8'd7, 8'd7, 8'd0);
    send_item(CMD_WRITE, 8'd40, 8'd40, 8'd100);
    send_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ, 8'd40, 8'd40, 8'd0);
    send_item(CMD_READ, 8'd255, 8'd255, 8'd0);
  endtask

  // empty map, single cell map, saturated sizes and register change without clear
  task automatic test_map_bounds();
    configure(0, 256, 3);
    send_item(CMD_WRITE, 8'd5, 8'd5, 8'd99);
    send_item(CMD_READ, 8'd5, 8'd5, 8'd0);
    configure(1, 1, 15);
    send_item(CMD_WRITE, 8'd0, 8'd0, 8'd80);
    send_item(CMD_READ, 8'd0, 8'd0, 8'd0);
    send_item(CMD_READ, 8'd1, 8'd0, 8'd0);
    send_item(CMD_READ, 8'd0, 8'd1, 8'd0);
    configure(300, 511, 0);
    send_item(CMD_READ, 8'd0, 8'd0, 8'd0);
    send_item(CMD_WRITE, 8'd255, 8'd0, 8'd60);
    send_item(CMD_READ, 8'd254, 8'd0, 8'd0);
    send_item(CMD_READ, 8'd255, 8'd0, 8'd0);
    send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
  endtask

  // receiver holds off while items keep coming back to back
  task automatic test_output_stall();
    configure(64, 64, 2);
    tx_no_idle = 1'b1;
    hold_req = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) begin
        send_item(CMD_WRITE, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
      end else begin
        send_item(CMD_READ, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
      end
    end
    tx_no_idle = 1'b0;
  endtask

  task automatic random_segment(input int seg);
    int ew, eh, r, pick, q, off;
    int cx, cy;
    bit have_center;
    logic [CmdW-1:0] cmd;
    logic [7:0] x, y, occ;
    case (seg)
      0: configure(256, 256, 15);
      1: configure(511, 300, 0);
      2: configure(1, 1, $urandom_range(0, 15));
      3: configure(0, $urandom_range(1, 256), $urandom_range(0, 15));
      4: configure($urandom_range(100, 256), $urandom_range(100, 256), $urandom_range(8, 15));
      default: configure($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 7));
    endcase
    if (seg == 5) begin
      tx_no_idle = 1'b1;
      rx_no_idle = 1'b1;
    end else begin
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
    end
    ew = grid_cols();
    eh = grid_rows();
    r = int'(radius_cfg);
    have_center = 1'b0;
    cx = 0;
    cy = 0;
    for (int i = 0; i < SegItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
      end else if (pick < 50 && have_center) begin
        off = int'($urandom_range(0, 2 * r + 2)) - (r + 1);
        x = 8'(cx + off);
        off = int'($urandom_range(0, 2 * r + 2)) - (r + 1);
        y = 8'(cy + off);
      end else begin
        x = 8'($urandom_range(0, (ew > 255) ? 255 : ew));
        y = 8'($urandom_range(0, (eh > 255) ? 255 : eh));
      end
      q = $urandom_range(0, 9);
      if (q < 4) begin
        occ = 8'($urandom_range(0, 50));
      end else if (q < 8) begin
        occ = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 5))
          0: occ = 8'd50;
          1: occ = 8'd51;
          2: occ = 8'd100;
          3: occ = 8'd127;
          4: occ = 8'h80;
          default: occ = 8'hFF;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_WRITE;
      else if (pick < 95) cmd = CMD_READ;
      else if (pick < 97) cmd = CMD_CLEAR;
      else cmd = CMD_UNUSED;
      send_item(cmd, x, y, occ);
      if (cmd == CMD_WRITE && int'(x) < ew && int'(y) < eh &&
          ($signed(occ) > ObstacleThreshold || $signed(occ) < 0)) begin
        have_center = 1'b1;
        cx = int'(x);
        cy = int'(y);
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_random();
    for (int seg = 0; seg < SegCount; seg++) begin
      random_segment(seg);
    end
  endtask

  // receiver: per result stall, plus the long hold-off
  always @(negedge clk_i) begin
    if (rx_hold || rx_stall != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (!rx_hold && rx_stall != 0) rx_stall--;
  end

  initial begin : hold_ctl
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        rx_hold = 1'b1;
        repeat (hold_req) @(posedge clk_i);
        rx_hold = 1'b0;
        hold_req = 0;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    cell_status_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.blocked = m_axis_tdata[0];
      got.raw_obstacle = m_axis_tdata[1];
      got.out_of_map = m_axis_tdata[2];
      reads_checked++;
      if (read_back_q.size() == 0) begin
        note_mismatch("result with no read pending", '0, got);
      end else begin
        want = read_back_q.pop_front();
        if (got != want) note_mismatch("read result mismatch", want, got);
      end
      rx_stall = rx_no_idle ? 0 : $urandom_range(0, 10);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reads still pending", cycle_cnt,
               read_back_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    test_directed();
    test_map_bounds();
    test_output_stall();
    test_random();
    wait_idle();
    $display("sent %0d items (%0d clears), checked %0d read results, %0d register writes",
             items_sent, clears_sent, reads_checked, reg_writes);
    $display("map sizes from empty to saturated, radius 0 to 15, %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
